>>> sv/sit_pkg.sv
// Shared constants and types for the segment intersection test.
package sit_pkg;

  // Width of every coordinate port of the top module.
  localparam int FIELD_BITS = 16;

  // Default number of coordinate bits that take part in the test.
  localparam int COORD_BITS_DEFAULT = 16;

  // Load enables for the three register stages of the orientation datapath.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

  // Sides of two points relative to a directed line: positive and negative flags.
  typedef struct packed {
    logic pos0;
    logic neg0;
    logic pos1;
    logic neg1;
  } side_t;

endpackage

>>> sv/sit_side.sv
// Pipelined orientation of two points against the line through one segment.
module sit_side #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  sit_pkg::pipe_en_t            en,
  input  logic signed [COORD_BITS-1:0] ox,
  input  logic signed [COORD_BITS-1:0] oy,
  input  logic signed [COORD_BITS-1:0] ex,
  input  logic signed [COORD_BITS-1:0] ey,
  input  logic signed [COORD_BITS-1:0] p0x,
  input  logic signed [COORD_BITS-1:0] p0y,
  input  logic signed [COORD_BITS-1:0] p1x,
  input  logic signed [COORD_BITS-1:0] p1y,
  output sit_pkg::side_t               side
);
  import sit_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  // Stage 1: direction of the line and offsets of both points from its origin.
  logic signed [DW-1:0] dx, dy, t0x, t0y, t1x, t1y;
  // Stage 2: the four partial products of the two cross products.
  logic signed [PW-1:0] m0a, m0b, m1a, m1b;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      dx  <= DW'(ex)  - DW'(ox);
      dy  <= DW'(ey)  - DW'(oy);
      t0x <= DW'(p0x) - DW'(ox);
      t0y <= DW'(p0y) - DW'(oy);
      t1x <= DW'(p1x) - DW'(ox);
      t1y <= DW'(p1y) - DW'(oy);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      m0a <= dx * t0y;
      m0b <= dy * t0x;
      m1a <= dx * t1y;
      m1b <= dy * t1x;
    end
  end

  // Stage 3: the sign of each cross product is a compare of its two terms.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      side.pos0 <= m0a > m0b;
      side.neg0 <= m0a < m0b;
      side.pos1 <= m1a > m1b;
      side.neg1 <= m1a < m1b;
    end
  end

endmodule

>>> sv/segment_intersection_test.sv
// Segment intersection test: decides whether two closed 2D segments share a point.
//
// Usage: the item channel (item_valid, item_stall) carries segment A
// (a_start, a_end) and segment B (b_start, b_end) as signed coordinates; only
// the low COORD_BITS bits of each port are used, zero-extended if narrower. The result
// channel (result_valid, result_stall) returns one bit, intersects, per item,
// in the order the items were accepted.
// Stage 1 forms coordinate differences and the bounding-box overlap, stage 2
// the multiplies, stage 3 the cross-product signs, stage 4 the decision.
// Throughput: one transaction per cycle unless stalled; multiplies set the clock.
// Reset clears all valid bits, so the pipeline comes out of reset empty.
// When the receiver stalls, the output register holds its result and each
// stage keeps filling until it holds an item; item_stall rises only when
// stage 1 is full and cannot advance. Nothing is dropped or repeated.
module segment_intersection_test #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic signed [sit_pkg::FIELD_BITS-1:0] a_start_x,
  input  logic signed [sit_pkg::FIELD_BITS-1:0] a_start_y,
  input  logic signed [sit_pkg::FIELD_BITS-1:0] a_end_x,
  input  logic signed [sit_pkg::FIELD_BITS-1:0] a_end_y,
  input  logic signed [sit_pkg::FIELD_BITS-1:0] b_start_x,
  input  logic signed [sit_pkg::FIELD_BITS-1:0] b_start_y,
  input  logic signed [sit_pkg::FIELD_BITS-1:0] b_end_x,
  input  logic signed [sit_pkg::FIELD_BITS-1:0] b_end_y,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              intersects
);
  import sit_pkg::*;

  localparam int WB = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;

  // Bits above COORD_BITS are dropped; a port narrower than COORD_BITS is zero-extended.
  function automatic logic signed [COORD_BITS-1:0] sx(input logic [FIELD_BITS-1:0] v);
    logic [WB-1:0] w;
    w = WB'(v);
    return signed'(w[COORD_BITS-1:0]);
  endfunction

  logic signed [COORD_BITS-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

  assign ax0 = sx(a_start_x);
  assign ay0 = sx(a_start_y);
  assign ax1 = sx(a_end_x);
  assign ay1 = sx(a_end_y);
  assign bx0 = sx(b_start_x);
  assign by0 = sx(b_start_y);
  assign bx1 = sx(b_end_x);
  assign by1 = sx(b_end_y);

  // Pipeline control: a stage loads when it is empty or the next one moves.
  logic     v1, v2, v3;
  pipe_en_t en;
  logic     en4;

  assign en4        = !result_valid || !result_stall;
  assign en.s3      = !v3 || en4;
  assign en.s2      = !v2 || en.s3;
  assign en.s1      = !v1 || en.s2;
  assign item_stall = !en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en.s1) v1 <= item_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en4)   result_valid <= v3;
    end
  end

  // Closed bounding-box overlap on both axes settles the fully degenerate case.
  logic signed [COORD_BITS-1:0] axl, axh, ayl, ayh, bxl, bxh, byl, byh;
  logic                         box1, box2, box3;

  always_comb begin
    axl = (ax0 < ax1) ? ax0 : ax1;
    axh = (ax0 > ax1) ? ax0 : ax1;
    ayl = (ay0 < ay1) ? ay0 : ay1;
    ayh = (ay0 > ay1) ? ay0 : ay1;
    bxl = (bx0 < bx1) ? bx0 : bx1;
    bxh = (bx0 > bx1) ? bx0 : bx1;
    byl = (by0 < by1) ? by0 : by1;
    byh = (by0 > by1) ? by0 : by1;
  end

  always_ff @(posedge clk) begin
    if (en.s1) box1 <= (axl <= bxh) && (bxl <= axh) && (ayl <= byh) && (byl <= ayh);
    if (en.s2) box2 <= box1;
    if (en.s3) box3 <= box2;
  end

  side_t side_a, side_b;

  // Ends of B against the line of A.
  sit_side #(.COORD_BITS(COORD_BITS)) u_side_a (
    .clk (clk), .en (en),
    .ox  (ax0), .oy  (ay0), .ex  (ax1), .ey  (ay1),
    .p0x (bx0), .p0y (by0), .p1x (bx1), .p1y (by1),
    .side(side_a)
  );

  // Ends of A against the line of B.
  sit_side #(.COORD_BITS(COORD_BITS)) u_side_b (
    .clk (clk), .en (en),
    .ox  (bx0), .oy  (by0), .ex  (bx1), .ey  (by1),
    .p0x (ax0), .p0y (ay0), .p1x (ax1), .p1y (ay1),
    .side(side_b)
  );

  // Stage 4: product signs of each side pair, then the decision.
  logic s1_neg, s1_pos, s2_neg, s2_pos, hit;

  always_comb begin
    s1_neg = (side_a.pos0 && side_a.neg1) || (side_a.neg0 && side_a.pos1);
    s1_pos = (side_a.pos0 && side_a.pos1) || (side_a.neg0 && side_a.neg1);
    s2_neg = (side_b.pos0 && side_b.neg1) || (side_b.neg0 && side_b.pos1);
    s2_pos = (side_b.pos0 && side_b.pos1) || (side_b.neg0 && side_b.neg1);
    priority if (s1_neg && s2_neg) begin
      hit = 1'b1;
    end else if (s1_pos || s2_pos) begin
      hit = 1'b0;
    end else if (s1_neg || s2_neg) begin
      // An end point lies on the other segment's line, inside its span.
      hit = 1'b1;
    end else begin
      hit = box3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) intersects <= hit;
  end

endmodule
